### rtl/core/ssp_pkg.sv
// Shared types, constants and codes for the shortest-path block.
`default_nettype none

package ssp_pkg;

    // Default vertex count
    localparam int SSP_VERTICES = 8;

    // Fixed field widths
    localparam int VTX_W  = 3;
    localparam int WGT_W  = 16;
    localparam int DIST_W = 24;

    // Weight at or above this value means no edge
    localparam logic signed [WGT_W-1:0] NO_EDGE = 16'sd9999;

    // Saturation limits of a distance, one bit wider than a distance
    localparam logic signed [DIST_W:0] DIST_MAX = 25'sd8388607;
    localparam logic signed [DIST_W:0] DIST_MIN = -25'sd8388608;

    // Item opcodes
    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_RUN   = 1'b1
    } t_ssp_op;

    // Controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INIT,
        S_READ,
        S_RELAX,
        S_OUT_READ,
        S_OUT_LOAD
    } t_ssp_state;

    // Controller to datapath commands
    typedef struct packed {
        logic clr_we;
        logic wt_we;
        logic run_start;
        logic init_we;
        logic relax_en;
        logic check_en;
        logic out_load;
    } t_ssp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
    } t_ssp_sts;

endpackage

`default_nettype wire

### rtl/core/ssp_if.sv
// Input and result channel interfaces of the shortest-path block.
`default_nettype none

interface ssp_in_if;
    import ssp_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    opcode;
    logic [VTX_W-1:0]        src_vertex;
    logic [VTX_W-1:0]        dst_vertex;
    logic signed [WGT_W-1:0] weight;

    modport source (output valid, opcode, src_vertex, dst_vertex, weight, input ready);
    modport sink   (input valid, opcode, src_vertex, dst_vertex, weight, output ready);
endinterface

interface ssp_out_if;
    import ssp_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [VTX_W-1:0]         vertex;
    logic signed [DIST_W-1:0] distance;
    logic                     reachable;
    logic                     negative_cycle;
    logic                     last;

    modport source (output valid, vertex, distance, reachable, negative_cycle, last,
                    input ready);
    modport sink   (input valid, vertex, distance, reachable, negative_cycle, last,
                    output ready);
endinterface

`default_nettype wire

### rtl/core/ssp_ctrl.sv
// Sequencer of the shortest-path block: clearing, loading, relaxation passes, readout.
`default_nettype none

module ssp_ctrl
    import ssp_pkg::*;
#(
    parameter int VERTICES = SSP_VERTICES
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    input  wire logic                                   i_opcode,
    output logic                                        o_in_ready,
    input  wire t_ssp_sts                               i_sts,
    output t_ssp_cmd                                    o_cmd,
    output logic [$clog2(VERTICES)-1:0]                 o_u,
    output logic [$clog2(VERTICES)-1:0]                 o_v,
    output logic [$clog2(VERTICES*VERTICES)-1:0]        o_clr
);

    localparam int IW = $clog2(VERTICES);
    localparam int CW = $clog2(VERTICES*VERTICES);

    t_ssp_state      r_state, n_state;
    logic [IW-1:0]   r_u, n_u;
    logic [IW-1:0]   r_v, n_v;
    logic [IW-1:0]   r_pass, n_pass;
    logic            r_check, n_check;
    logic [CW-1:0]   r_clr, n_clr;
    logic            u_last, v_last, pass_last;

    assign u_last    = (r_u == IW'(VERTICES-1));
    assign v_last    = (r_v == IW'(VERTICES-1));
    assign pass_last = (r_pass == IW'(VERTICES-2));

    assign o_u   = r_u;
    assign o_v   = r_v;
    assign o_clr = r_clr;

    // Hold state and loop counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_u     <= '0;
            r_v     <= '0;
            r_pass  <= '0;
            r_check <= 1'b0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_u     <= n_u;
            r_v     <= n_v;
            r_pass  <= n_pass;
            r_check <= n_check;
            r_clr   <= n_clr;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_u        = r_u;
        n_v        = r_v;
        n_pass     = r_pass;
        n_check    = r_check;
        n_clr      = r_clr;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                if (r_clr == CW'(VERTICES*VERTICES-1)) begin
                    n_clr   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_opcode == OP_RUN) begin
                        o_cmd.run_start = 1'b1;
                        n_u             = '0;
                        n_state         = S_INIT;
                    end else begin
                        o_cmd.wt_we = 1'b1;
                    end
                end
            end
            S_INIT: begin
                o_cmd.init_we = 1'b1;
                if (u_last) begin
                    n_u     = '0;
                    n_v     = '0;
                    n_pass  = '0;
                    n_check = 1'b0;
                    n_state = S_READ;
                end else begin
                    n_u = r_u + 1'b1;
                end
            end
            S_READ: begin
                n_state = S_RELAX;
            end
            S_RELAX: begin
                if (r_check) begin
                    o_cmd.check_en = 1'b1;
                end else begin
                    o_cmd.relax_en = 1'b1;
                end
                n_state = S_READ;
                if (v_last) begin
                    n_v = '0;
                    if (u_last) begin
                        n_u = '0;
                        if (r_check) begin
                            n_check = 1'b0;
                            n_state = S_OUT_READ;
                        end else if (pass_last) begin
                            n_pass  = '0;
                            n_check = 1'b1;
                        end else begin
                            n_pass = r_pass + 1'b1;
                        end
                    end else begin
                        n_u = r_u + 1'b1;
                    end
                end else begin
                    n_v = r_v + 1'b1;
                end
            end
            S_OUT_READ: begin
                n_state = S_OUT_LOAD;
            end
            S_OUT_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (u_last) begin
                        n_u     = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_u     = r_u + 1'b1;
                        n_state = S_OUT_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/ssp_dpath.sv
// Datapath of the shortest-path block: weight and distance memories, relax unit, result register.
`default_nettype none

module ssp_dpath
    import ssp_pkg::*;
#(
    parameter int VERTICES = SSP_VERTICES
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire t_ssp_cmd                               i_cmd,
    output t_ssp_sts                                    o_sts,
    input  wire logic [$clog2(VERTICES)-1:0]            i_u,
    input  wire logic [$clog2(VERTICES)-1:0]            i_v,
    input  wire logic [$clog2(VERTICES*VERTICES)-1:0]   i_clr,
    input  wire logic [VTX_W-1:0]                       i_src_vertex,
    input  wire logic [VTX_W-1:0]                       i_dst_vertex,
    input  wire logic signed [WGT_W-1:0]                i_weight,
    output logic                                        o_valid,
    input  wire logic                                   i_ready,
    output logic [VTX_W-1:0]                            o_vertex,
    output logic signed [DIST_W-1:0]                    o_distance,
    output logic                                        o_reachable,
    output logic                                        o_negative_cycle,
    output logic                                        o_last
);

    localparam int IW = $clog2(VERTICES);
    localparam int WAW = $clog2(VERTICES*VERTICES);

    // Weight matrix and per-vertex {reached, distance} words
    logic [WGT_W-1:0]  r_wmem [VERTICES*VERTICES];
    logic [DIST_W:0]   r_dmem [VERTICES];

    logic [WGT_W-1:0]         r_w_rd;
    logic [DIST_W:0]          r_da;
    logic [DIST_W:0]          r_db;
    logic [VTX_W-1:0]         r_start;
    logic                     r_cycle;
    logic                     r_out_valid;
    logic [VTX_W-1:0]         r_out_vertex;
    logic signed [DIST_W-1:0] r_out_dist;
    logic                     r_out_reach;
    logic                     r_out_cycle;
    logic                     r_out_last;

    logic                     wt_ok;
    logic                     w_we;
    logic [WAW-1:0]           w_waddr;
    logic [WGT_W-1:0]         w_wdata;
    logic [WAW-1:0]           w_raddr;
    logic                     d_we;
    logic [IW-1:0]            d_waddr;
    logic [DIST_W:0]          d_wdata;
    logic signed [WGT_W-1:0]  wt;
    logic signed [DIST_W-1:0] da;
    logic signed [DIST_W-1:0] db;
    logic signed [DIST_W:0]   sum;
    logic signed [DIST_W-1:0] cand;
    logic                     improve;
    logic                     is_start;

    assign o_sts.out_free = !r_out_valid || i_ready;

    // Select weight write: clearing sweep or an edge item inside the matrix
    assign wt_ok = (32'(i_src_vertex) < 32'(VERTICES)) && (32'(i_dst_vertex) < 32'(VERTICES));
    always_comb begin
        w_we    = i_cmd.clr_we || (i_cmd.wt_we && wt_ok);
        w_waddr = i_clr;
        w_wdata = NO_EDGE;
        if (i_cmd.wt_we) begin
            w_waddr = WAW'(32'(i_src_vertex) * 32'(VERTICES) + 32'(i_dst_vertex));
            w_wdata = (i_weight >= NO_EDGE) ? NO_EDGE : i_weight;
        end
    end
    assign w_raddr = WAW'(32'(i_u) * 32'(VERTICES) + 32'(i_v));

    // Write and read the weight matrix
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_wmem[w_waddr] <= w_wdata;
        end
        r_w_rd <= r_wmem[w_raddr];
    end

    // Relax edge u->v from the registered reads
    assign wt  = r_w_rd;
    assign da  = r_da[DIST_W-1:0];
    assign db  = r_db[DIST_W-1:0];
    assign sum = {da[DIST_W-1], da} + {{(DIST_W+1-WGT_W){wt[WGT_W-1]}}, wt};
    always_comb begin
        if (sum > DIST_MAX) begin
            cand = DIST_MAX[DIST_W-1:0];
        end else if (sum < DIST_MIN) begin
            cand = DIST_MIN[DIST_W-1:0];
        end else begin
            cand = sum[DIST_W-1:0];
        end
    end
    assign improve = r_da[DIST_W] && (wt < NO_EDGE) && (!r_db[DIST_W] || (cand < db));

    // Select distance write: start-of-run init at u or an improvement at v
    assign is_start = (32'(i_u) == 32'(r_start));
    always_comb begin
        d_we    = i_cmd.init_we || (i_cmd.relax_en && improve);
        d_waddr = i_v;
        d_wdata = {1'b1, cand};
        if (i_cmd.init_we) begin
            d_waddr = i_u;
            d_wdata = {is_start, {DIST_W{1'b0}}};
        end
    end

    // Write and read the distance memory
    always_ff @(posedge i_clk) begin
        if (d_we) begin
            r_dmem[d_waddr] <= d_wdata;
        end
        r_da <= r_dmem[i_u];
        r_db <= r_dmem[i_v];
    end

    // Latch the start vertex and track the negative-cycle flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycle <= 1'b0;
        end else if (i_cmd.run_start) begin
            r_cycle <= 1'b0;
        end else if (i_cmd.check_en && improve) begin
            r_cycle <= 1'b1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.run_start) begin
            r_start <= i_src_vertex;
        end
    end

    // Load or drop the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_vertex <= VTX_W'(i_u);
            r_out_dist   <= r_da[DIST_W] ? r_da[DIST_W-1:0] : '0;
            r_out_reach  <= r_da[DIST_W];
            r_out_cycle  <= r_cycle;
            r_out_last   <= (i_u == IW'(VERTICES-1));
        end
    end

    assign o_valid          = r_out_valid;
    assign o_vertex         = r_out_vertex;
    assign o_distance       = r_out_dist;
    assign o_reachable      = r_out_reach;
    assign o_negative_cycle = r_out_cycle;
    assign o_last           = r_out_last;

endmodule

`default_nettype wire

### rtl/core/single_source_shortest_path.sv
// Bellman-Ford shortest path over a dense weight matrix, top level.
// Reset: synchronous, active low; a clearing pass then sets every weight to no edge,
//   and no item is accepted until it ends.
// Edge write items: one per cycle while the block is idle, no result.
// Run items: an init step per vertex, then VERTICES passes (VERTICES-1 relaxing, one checking)
//   of VERTICES*VERTICES relaxations, each a read step (weight and distances) then a relax step,
//   then per result a distance read and a load that waits for the result register to be free.
`default_nettype none

module single_source_shortest_path
    import ssp_pkg::*;
#(
    parameter int VERTICES = SSP_VERTICES
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ssp_in_if.sink    i_in,
    ssp_out_if.source o_out
);

    localparam int IW = $clog2(VERTICES);
    localparam int CW = $clog2(VERTICES*VERTICES);

    t_ssp_cmd      cmd;
    t_ssp_sts      sts;
    logic [IW-1:0] idx_u;
    logic [IW-1:0] idx_v;
    logic [CW-1:0] idx_clr;

    // Sequencer
    ssp_ctrl #(
        .VERTICES (VERTICES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_opcode   (i_in.opcode),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_u        (idx_u),
        .o_v        (idx_v),
        .o_clr      (idx_clr)
    );

    // Memories, relax unit and result register
    ssp_dpath #(
        .VERTICES (VERTICES)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_u              (idx_u),
        .i_v              (idx_v),
        .i_clr            (idx_clr),
        .i_src_vertex     (i_in.src_vertex),
        .i_dst_vertex     (i_in.dst_vertex),
        .i_weight         (i_in.weight),
        .o_valid          (o_out.valid),
        .i_ready          (o_out.ready),
        .o_vertex         (o_out.vertex),
        .o_distance       (o_out.distance),
        .o_reachable      (o_out.reachable),
        .o_negative_cycle (o_out.negative_cycle),
        .o_last           (o_out.last)
    );

endmodule

`default_nettype wire

### rtl/core/ssp_checker.sv
// Port-level checks of the shortest-path block and their binding to the top level.
`default_nettype none

module ssp_checker
    import ssp_pkg::*;
#(
    parameter int VERTICES = SSP_VERTICES
) (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     i_in_ready,
    input wire logic                     i_out_valid,
    input wire logic                     i_out_ready,
    input wire logic [VTX_W-1:0]         i_vertex,
    input wire logic signed [DIST_W-1:0] i_distance,
    input wire logic                     i_reachable,
    input wire logic                     i_negative_cycle,
    input wire logic                     i_last
);

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_vertex)
            && $stable(i_distance) && $stable(i_reachable) && $stable(i_last))
        else $error("stalled result changed");

    // No new item while a run still has results to deliver
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_last |-> !i_in_ready)
        else $error("item accepted in the middle of a run");

    // Final result names the final vertex
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_last |-> i_vertex == VTX_W'(VERTICES-1))
        else $error("last flag on the wrong vertex");

    // Advance vertex by one with the same cycle flag within a run
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_last |=> !i_out_valid
            || (i_vertex == $past(i_vertex) + 1'b1
                && i_negative_cycle == $past(i_negative_cycle)))
        else $error("result order or cycle flag broken");

    // Report zero distance for an unreached vertex
    a_unreached: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_reachable |-> i_distance == '0)
        else $error("unreached vertex with nonzero distance");

endmodule

bind single_source_shortest_path ssp_checker #(
    .VERTICES (VERTICES)
) u_ssp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_vertex         (o_out.vertex),
    .i_distance       (o_out.distance),
    .i_reachable      (o_out.reachable),
    .i_negative_cycle (o_out.negative_cycle),
    .i_last           (o_out.last)
);

`default_nettype wire

### tb/single_source_shortest_path_tb.sv
// Self-checking testbench for the shortest-path block: directed table, then random traffic.
`timescale 1ns / 100ps

module single_source_shortest_path_tb;
    import ssp_pkg::*;

    localparam int NV          = SSP_VERTICES;
    localparam int RAND_ITEMS  = 330;
    localparam int LONG_HOLD   = 2500;
    localparam int TAIL_CYCLES = 2200;
    localparam int LIMIT       = 2000000;

    // One row of stimulus; typed rows carry their expected results by hand
    typedef struct packed {
        t_ssp_op                   op;
        logic [VTX_W-1:0]          src;
        logic [VTX_W-1:0]          dst;
        logic signed [WGT_W-1:0]   weight;
        logic                      typed;
        logic [NV-1:0]             exp_reach;
        logic                      exp_cycle;
        logic [NV-1:0][DIST_W-1:0] exp_dist;
    } stim_row_t;

    typedef struct {
        logic [VTX_W-1:0]         vertex;
        logic signed [DIST_W-1:0] distance;
        logic                     reachable;
        logic                     negative_cycle;
        logic                     last;
    } vertex_report_t;

    // Directed table; exp_dist is listed from vertex 7 down to vertex 0
    localparam stim_row_t DIRECTED [23] = '{
        '{OP_RUN,   3'd3, 3'd5, 16'sd0,     1'b1, 8'h08, 1'b0, '0},
        '{OP_RUN,   3'd7, 3'd7, 16'shFFFF,  1'b1, 8'h80, 1'b0, '0},
        '{OP_RUN,   3'd0, 3'd0, 16'sd0,     1'b1, 8'h01, 1'b0, '0},
        '{OP_WRITE, 3'd3, 3'd7, 16'sh8000,  1'b0, 8'h00, 1'b0, '0},
        '{OP_WRITE, 3'd7, 3'd0, 16'sd9998,  1'b0, 8'h00, 1'b0, '0},
        '{OP_WRITE, 3'd3, 3'd5, 16'sd9999,  1'b0, 8'h00, 1'b0, '0},
        '{OP_WRITE, 3'd3, 3'd6, 16'sh7FFF,  1'b0, 8'h00, 1'b0, '0},
        '{OP_WRITE, 3'd0, 3'd0, 16'sd0,     1'b0, 8'h00, 1'b0, '0},
        '{OP_RUN,   3'd3, 3'd2, 16'sd0,     1'b1, 8'h89, 1'b0,
          {24'shFF8000, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, -24'sd22770}},
        '{OP_WRITE, 3'd1, 3'd2, 16'sh8000,  1'b0, 8'h00, 1'b0, '0},
        '{OP_WRITE, 3'd0, 3'd5, 16'sd5,     1'b0, 8'h00, 1'b0, '0},
        '{OP_WRITE, 3'd5, 3'd6, -16'sd3,    1'b0, 8'h00, 1'b0, '0},
        '{OP_WRITE, 3'd6, 3'd5, 16'sd3,     1'b0, 8'h00, 1'b0, '0},
        '{OP_RUN,   3'd7, 3'd1, 16'sd77,    1'b0, 8'h00, 1'b0, '0},
        '{OP_WRITE, 3'd6, 3'd6, 16'shFFFF,  1'b0, 8'h00, 1'b0, '0},
        '{OP_RUN,   3'd3, 3'd4, 16'sd0,     1'b0, 8'h00, 1'b0, '0},
        '{OP_RUN,   3'd1, 3'd6, 16'sh5555,  1'b0, 8'h00, 1'b0, '0},
        '{OP_WRITE, 3'd6, 3'd6, 16'sd20000, 1'b0, 8'h00, 1'b0, '0},
        '{OP_WRITE, 3'd7, 3'd7, 16'sh8000,  1'b0, 8'h00, 1'b0, '0},
        '{OP_RUN,   3'd7, 3'd3, 16'shAAAA,  1'b0, 8'h00, 1'b0, '0},
        '{OP_WRITE, 3'd7, 3'd7, 16'sd9999,  1'b0, 8'h00, 1'b0, '0},
        '{OP_RUN,   3'd3, 3'd0, 16'sd0,     1'b0, 8'h00, 1'b0, '0},
        '{OP_RUN,   3'd5, 3'd2, 16'sd1,     1'b0, 8'h00, 1'b0, '0}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    ssp_in_if  in_ch ();
    ssp_out_if out_ch ();

    single_source_shortest_path #(
        .VERTICES (NV)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    logic signed [WGT_W-1:0] wt_matrix [NV][NV];
    vertex_report_t          expected_reports [$];
    int                      error_count  = 0;
    int                      reports_seen = 0;
    int                      cycle_count  = 0;
    bit                      idle_on      = 1'b1;
    bit                      calm         = 1'b0;

    always #1 i_clk = ~i_clk;

    // Track one accepted item: store a weight, or solve the graph and queue the reports
    function automatic void model_item(input stim_row_t row);
        int             path_len [NV];
        bit             seen [NV];
        bit             loop_found;
        int             cand;
        int             wt;
        vertex_report_t rep;
        if (row.op == OP_WRITE) begin
            wt_matrix[row.src][row.dst] = (row.weight >= NO_EDGE) ? NO_EDGE : row.weight;
            return;
        end
        for (int i = 0; i < NV; i++) begin
            path_len[i] = 0;
            seen[i]     = (i == row.src);
        end
        loop_found = 1'b0;
        // Relax in place NV-1 times; the final pass only looks for an improvement
        for (int p = 0; p < NV; p++) begin
            for (int u = 0; u < NV; u++) begin
                for (int v = 0; v < NV; v++) begin
                    wt = wt_matrix[u][v];
                    if (seen[u] && wt < NO_EDGE) begin
                        cand = path_len[u] + wt;
                        if (cand > DIST_MAX) cand = DIST_MAX;
                        else if (cand < DIST_MIN) cand = DIST_MIN;
                        if (!seen[v] || cand < path_len[v]) begin
                            if (p == NV - 1) begin
                                loop_found = 1'b1;
                            end else begin
                                path_len[v] = cand;
                                seen[v]     = 1'b1;
                            end
                        end
                    end
                end
            end
        end
        for (int i = 0; i < NV; i++) begin
            rep.vertex         = VTX_W'(i);
            rep.distance       = seen[i] ? DIST_W'(path_len[i]) : '0;
            rep.reachable      = seen[i];
            rep.negative_cycle = loop_found;
            rep.last           = (i == NV - 1);
            expected_reports.push_back(rep);
        end
    endfunction

    function automatic stim_row_t make_row(input t_ssp_op op, input int src, input int dst,
                                           input logic signed [WGT_W-1:0] w);
        stim_row_t row;
        row        = '0;
        row.op     = op;
        row.src    = VTX_W'(src);
        row.dst    = VTX_W'(dst);
        row.weight = w;
        return row;
    endfunction

    // Short positive edges most often, some removals, some negatives and extremes
    function automatic logic signed [WGT_W-1:0] pick_weight();
        int sel;
        int v;
        sel = $urandom_range(0, 99);
        if (sel < 45)      v = $urandom_range(0, 500);
        else if (sel < 65) v = $urandom_range(9999, 32767);
        else if (sel < 80) v = -int'($urandom_range(1, 100));
        else if (sel < 85) v = -32768;
        else if (sel < 90) v = 9998;
        else               v = int'($urandom);
        return WGT_W'(v);
    endfunction

    // Offer one item, hold it until accepted, then record what it should cause
    task automatic send_item(input stim_row_t row);
        int             gap;
        vertex_report_t rep;
        gap = 0;
        if (idle_on && !calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 14);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.opcode     <= row.op;
        in_ch.src_vertex <= row.src;
        in_ch.dst_vertex <= row.dst;
        in_ch.weight     <= row.weight;
        do @(posedge i_clk); while (!in_ch.ready);
        if (row.typed) begin
            for (int v = 0; v < NV; v++) begin
                rep.vertex         = VTX_W'(v);
                rep.distance       = row.exp_reach[v] ? row.exp_dist[v] : '0;
                rep.reachable      = row.exp_reach[v];
                rep.negative_cycle = row.exp_cycle;
                rep.last           = (v == NV - 1);
                expected_reports.push_back(rep);
            end
        end else begin
            model_item(row);
        end
    endtask

    // Stimulus: reset, directed table, then random sequences
    initial begin : drive_items
        int        rand_sent;
        int        seq_count;
        int        kind;
        int        nwr;
        int        row_src;
        stim_row_t row;
        rand_sent = 0;
        seq_count = 0;
        for (int u = 0; u < NV; u++)
            for (int v = 0; v < NV; v++)
                wt_matrix[u][v] = NO_EDGE;
        in_ch.valid      = 1'b0;
        in_ch.opcode     = OP_WRITE;
        in_ch.src_vertex = '0;
        in_ch.dst_vertex = '0;
        in_ch.weight     = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i]) send_item(DIRECTED[i]);

        while (rand_sent < RAND_ITEMS) begin
            idle_on = ($urandom_range(0, 3) != 0);
            calm    = (rand_sent >= RAND_ITEMS - 40);
            // Once, let every pending report drain before offering more
            if (seq_count == 12) begin
                in_ch.valid <= 1'b0;
                do @(posedge i_clk); while (expected_reports.size() != 0);
            end
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                // Wipe one row of the matrix to keep the graph sparse
                row_src = $urandom_range(0, NV - 1);
                for (int j = 0; j < NV; j++) begin
                    send_item(make_row(OP_WRITE, row_src, j,
                                       WGT_W'($urandom_range(9999, 32767))));
                    rand_sent++;
                end
            end else if (kind == 1) begin
                // Lone item with every field random
                row = make_row(t_ssp_op'($urandom_range(0, 1)), $urandom_range(0, NV - 1),
                               $urandom_range(0, NV - 1), WGT_W'($urandom));
                send_item(row);
                rand_sent++;
            end else begin
                // A few edge writes, then a run from a random start
                nwr = $urandom_range(1, 10);
                repeat (nwr) begin
                    send_item(make_row(OP_WRITE, $urandom_range(0, NV - 1),
                                       $urandom_range(0, NV - 1), pick_weight()));
                    rand_sent++;
                end
                send_item(make_row(OP_RUN, $urandom_range(0, NV - 1),
                                   $urandom_range(0, NV - 1), WGT_W'($urandom)));
                rand_sent++;
            end
            seq_count++;
        end

        // Drain, then give the block time to show any stray result
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (expected_reports.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_reports.size() == 0) begin
            $display("single_source_shortest_path_tb: done, clean");
        end else begin
            $display("single_source_shortest_path_tb: done, errors");
        end
        $finish;
    end

    // Result side: random stalls, plus one long hold-off to back the block up
    initial begin : drive_ready
        bit long_hold_done;
        long_hold_done = 1'b0;
        out_ch.ready   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!long_hold_done && reports_seen >= 24) begin
                long_hold_done = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    // Compare each accepted report with the oldest one expected
    always @(posedge i_clk) begin : check_reports
        vertex_report_t want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            reports_seen++;
            if (expected_reports.size() == 0) begin
                $error("unexpected report for vertex %0d", out_ch.vertex);
                error_count++;
            end else begin
                want = expected_reports.pop_front();
                if (out_ch.vertex !== want.vertex) begin
                    $error("vertex: expected %0d, got %0d", want.vertex, out_ch.vertex);
                    error_count++;
                end
                if (out_ch.distance !== want.distance) begin
                    $error("distance: expected %0d, got %0d", want.distance, out_ch.distance);
                    error_count++;
                end
                if (out_ch.reachable !== want.reachable) begin
                    $error("reachable: expected %0d, got %0d", want.reachable,
                           out_ch.reachable);
                    error_count++;
                end
                if (out_ch.negative_cycle !== want.negative_cycle) begin
                    $error("negative_cycle: expected %0d, got %0d", want.negative_cycle,
                           out_ch.negative_cycle);
                    error_count++;
                end
                if (out_ch.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, out_ch.last);
                    error_count++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("single_source_shortest_path_tb: done, errors");
            $finish;
        end
    end

endmodule
